/* hw/rtl/affra_pkg.sv */
// Shared types, constants and helper functions of the aligned first-fit range allocator.
package affra_pkg;

	localparam int MAX_RANGES = 64;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 1'b1;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_ALLOC  = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERLAP  = 3'd1,
		ST_NOFIT    = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] length;
		logic [7:0]  tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		action_t     act;
		logic [63:0] base;
		logic [64:0] fend;
		logic [63:0] len;
		logic [63:0] mask;
		logic [7:0]  tag;
		logic [63:0] addr;
	} job_t;

	typedef struct packed {
		logic             valid;
		logic             overlap;
		logic             lower;
		logic             match;
		logic             fit;
		logic             tail_fit;
		logic [63:0]      aln;
		logic [IDX_W-1:0] idx;
		entry_t           ent;
	} eval_t;

	// round a 65-bit gap base up to the alignment; top bit of result is "usable"
	function automatic logic [64:0] round_up(input logic [64:0] gb, input logic [63:0] mask);
		logic [64:0] s;
		s = {1'b0, gb[63:0]} + {1'b0, mask};
		return {~gb[64] & ~s[64], s[63:0] & ~mask};
	endfunction

	function automatic logic fits(input logic [63:0] aln, input logic [63:0] ge,
			input logic [63:0] len);
		logic [64:0] e;
		e = {1'b0, aln} + {1'b0, len};
		return (aln < ge) && (e <= {1'b0, ge});
	endfunction

endpackage

/* hw/rtl/affra_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module affra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/affra_eval.sv */
// Per-entry evaluation stage: range ends, overlap, lookup match and aligned gap tests.
module affra_eval import affra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_v,
	input  logic [IDX_W-1:0] rd_ix,
	input  entry_t           rd_ent,
	input  logic             init,
	input  job_t             job,
	input  logic [63:0]      win_start,
	input  logic [63:0]      win_end,
	output eval_t            ev
);

	logic             v_s1;
	logic [IDX_W-1:0] ix_s1;
	entry_t           ent_s1;
	logic [64:0]      end_s1;
	logic [63:0]      ge_s1;
	logic [63:0]      aln_q;
	logic             aln_ok_q;
	logic [64:0]      gb_next;
	logic [64:0]      rnd_next;
	logic [64:0]      rnd_init;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= rd_v;
		end
	end

	always_ff @(posedge clk) begin
		ix_s1  <= rd_ix;
		ent_s1 <= rd_ent;
		end_s1 <= {1'b0, rd_ent.base} + {1'b0, rd_ent.length};
		ge_s1  <= (rd_ent.base < win_end) ? rd_ent.base : win_end;
	end

	assign gb_next  = ({1'b0, win_start} < end_s1) ? end_s1 : {1'b0, win_start};
	assign rnd_next = round_up(gb_next, job.mask);
	assign rnd_init = round_up({1'b0, win_start}, job.mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aln_ok_q <= 1'b0;
			aln_q    <= '0;
		end else if (init) begin
			aln_ok_q <= rnd_init[64];
			aln_q    <= rnd_init[63:0];
		end else if (v_s1) begin
			aln_ok_q <= rnd_next[64];
			aln_q    <= rnd_next[63:0];
		end
	end

	always_comb begin
		ev.valid    = v_s1;
		ev.overlap  = ({1'b0, job.base} < end_s1) && ({1'b0, ent_s1.base} < job.fend);
		ev.lower    = ent_s1.base <= job.base;
		ev.match    = (job.addr >= ent_s1.base) && ({1'b0, job.addr} < end_s1);
		ev.fit      = aln_ok_q && fits(aln_q, ge_s1, job.len);
		ev.tail_fit = aln_ok_q && fits(aln_q, win_end, job.len);
		ev.aln      = aln_q;
		ev.idx      = ix_s1;
		ev.ent      = ent_s1;
	end

endmodule

/* hw/rtl/aligned_first_fit_range_allocator_top.sv */
// Top level of the aligned first-fit range allocator: sequencer, table RAM and config.
//
// One request at a time: start is taken while busy is low, and exactly one result
// follows with done high for one cycle. The receiver cannot stall it. The range
// table lives in one RAM read one entry per cycle; a request scans every stored
// entry, and an insert or allocate that succeeds at position p then moves the later
// entries up one place and writes the new one. Requests refused because the table
// is full, and unused action codes, are answered from idle without a scan.
module aligned_first_fit_range_allocator_top import affra_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           action,
	input  logic [63:0]          fixed_base,
	input  logic [63:0]          length,
	input  logic [5:0]           align_log2,
	input  logic [7:0]           range_id,
	input  logic [63:0]          lookup_addr,
	output logic                 done,
	output logic [2:0]           status,
	output logic [63:0]          result_base,
	output logic [63:0]          result_length,
	output logic [7:0]           result_id,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [63:0]          cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_SHIFT,
		S_PUT
	} state_t;

	state_t           state_q;
	job_t             job_q;
	logic [63:0]      window_start_q;
	logic [63:0]      window_end_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             rd_v_q;
	logic [IDX_W-1:0] rd_ix_q;
	logic             ovl_q;
	logic             fit_q;
	logic             fnd_q;
	logic [CNT_W-1:0] pos_q;
	logic [63:0]      chosen_q;
	entry_t           fent_q;
	entry_t           new_q;
	logic [CNT_W-1:0] sj_q;
	logic             sh_v_q;
	logic [IDX_W-1:0] sh_addr_q;
	logic             done_q;
	status_t          status_q;
	entry_t           res_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [CNT_W-1:0] sj_m1;
	logic             init;
	eval_t            ev;
	action_t          act_in;

	assign act_in = action_t'(action);
	assign sj_m1  = sj_q - 1'b1;
	assign init   = (state_q == S_PREP);

	always_comb begin
		ram_raddr = rd_cnt_q[IDX_W-1:0];
		if (state_q == S_SHIFT) begin
			ram_raddr = sj_m1[IDX_W-1:0];
		end
		ram_we    = sh_v_q;
		ram_waddr = sh_addr_q;
		ram_wdata = entry_t'(ram_rdata);
		if (state_q == S_PUT) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q[IDX_W-1:0];
			ram_wdata = new_q;
		end
	end

	affra_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_RANGES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	affra_eval u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_v     (rd_v_q),
		.rd_ix    (rd_ix_q),
		.rd_ent   (entry_t'(ram_rdata)),
		.init     (init),
		.job      (job_q),
		.win_start(window_start_q),
		.win_end  (window_end_q),
		.ev       (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= '0;
			window_end_q   <= '1;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_WINDOW_START: window_start_q <= cfg_data;
				REG_WINDOW_END:   window_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_ix_q <= rd_cnt_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			job_q     <= '0;
			cnt_q     <= '0;
			rd_cnt_q  <= '0;
			rd_v_q    <= 1'b0;
			ovl_q     <= 1'b0;
			fit_q     <= 1'b0;
			fnd_q     <= 1'b0;
			pos_q     <= '0;
			chosen_q  <= '0;
			fent_q    <= '0;
			new_q     <= '0;
			sj_q      <= '0;
			sh_v_q    <= 1'b0;
			sh_addr_q <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			rd_v_q <= 1'b0;
			sh_v_q <= 1'b0;
			if (ev.valid) begin
				unique case (job_q.act)
					ACT_INSERT: begin
						if (ev.overlap) begin
							ovl_q <= 1'b1;
						end
						if (ev.lower) begin
							pos_q <= pos_q + 1'b1;
						end
					end
					ACT_ALLOC: begin
						if (!fit_q && ev.fit) begin
							fit_q    <= 1'b1;
							chosen_q <= ev.aln;
							pos_q    <= CNT_W'(ev.idx);
						end
					end
					ACT_LOOKUP: begin
						if (!fnd_q && ev.match) begin
							fnd_q  <= 1'b1;
							fent_q <= ev.ent;
						end
					end
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						job_q.act  <= act_in;
						job_q.base <= fixed_base;
						job_q.fend <= {1'b0, fixed_base} + {1'b0, length};
						job_q.len  <= length;
						job_q.mask <= (64'd1 << align_log2) - 64'd1;
						job_q.tag  <= range_id;
						job_q.addr <= lookup_addr;
						ovl_q      <= 1'b0;
						fit_q      <= 1'b0;
						fnd_q      <= 1'b0;
						pos_q      <= '0;
						rd_cnt_q   <= '0;
						if (act_in == ACT_NONE) begin
							done_q   <= 1'b1;
							status_q <= ST_NOTFOUND;
							res_q    <= '0;
						end else if (act_in != ACT_LOOKUP && cnt_q == CNT_W'(MAX_RANGES)) begin
							done_q   <= 1'b1;
							status_q <= ST_FULL;
							res_q    <= '0;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					state_q <= (cnt_q == '0) ? S_DECIDE : S_SCAN;
				end
				S_SCAN: begin
					rd_v_q   <= 1'b1;
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == cnt_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_v_q && !ev.valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					sj_q    <= cnt_q;
					state_q <= S_IDLE;
					unique case (job_q.act)
						ACT_INSERT: begin
							if (ovl_q) begin
								done_q   <= 1'b1;
								status_q <= ST_OVERLAP;
								res_q    <= '0;
							end else begin
								new_q   <= '{base: job_q.base, length: job_q.len, tag: job_q.tag};
								state_q <= S_SHIFT;
							end
						end
						ACT_ALLOC: begin
							if (fit_q) begin
								new_q   <= '{base: chosen_q, length: job_q.len, tag: job_q.tag};
								state_q <= S_SHIFT;
							end else if (ev.tail_fit) begin
								new_q   <= '{base: ev.aln, length: job_q.len, tag: job_q.tag};
								pos_q   <= cnt_q;
								state_q <= S_SHIFT;
							end else begin
								done_q   <= 1'b1;
								status_q <= ST_NOFIT;
								res_q    <= '0;
							end
						end
						ACT_LOOKUP: begin
							done_q   <= 1'b1;
							status_q <= fnd_q ? ST_OK : ST_NOTFOUND;
							res_q    <= fnd_q ? fent_q : '0;
						end
						default: begin
							done_q   <= 1'b1;
							status_q <= ST_NOTFOUND;
							res_q    <= '0;
						end
					endcase
				end
				S_SHIFT: begin
					if (sj_q > pos_q) begin
						sh_v_q    <= 1'b1;
						sh_addr_q <= sj_q[IDX_W-1:0];
						sj_q      <= sj_m1;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					cnt_q    <= cnt_q + 1'b1;
					done_q   <= 1'b1;
					status_q <= ST_OK;
					res_q    <= new_q;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign result_base   = res_q.base;
	assign result_length = res_q.length;
	assign result_id     = res_q.tag;

endmodule

/* verif/tb.sv */
// Self-checking testbench of the aligned first-fit range allocator with a predictor of the range table.
module tb;
	import affra_pkg::*;

	typedef struct {
		logic [1:0]  act;
		logic [63:0] base;
		logic [63:0] len;
		logic [5:0]  aln;
		logic [7:0]  tag;
		logic [63:0] addr;
	} req_t;

	typedef struct {
		logic [2:0]  st;
		logic [63:0] rb;
		logic [63:0] rl;
		logic [7:0]  rt;
	} resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = '0;
	logic [63:0] fixed_base = '0;
	logic [63:0] length = '0;
	logic [5:0] align_log2 = '0;
	logic [7:0] range_id = '0;
	logic [63:0] lookup_addr = '0;
	logic done;
	logic [2:0] status;
	logic [63:0] result_base;
	logic [63:0] result_length;
	logic [7:0] result_id;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [63:0] cfg_data = '0;

	aligned_first_fit_range_allocator_top dut (.*);

	always #6 clk = ~clk;

	req_t pending[$];
	resp_t expected_resp[$];
	logic [63:0] tbl_base[MAX_RANGES];
	logic [63:0] tbl_len[MAX_RANGES];
	logic [7:0] tbl_tag[MAX_RANGES];
	int tbl_count;
	logic [63:0] win_lo, win_hi;
	int send_idle_pct;
	int mismatches = 0;
	int stall_cycles = 0;
	int n_sent = 0;
	int n_done = 0;
	bit took = 1'b0;

	function automatic logic [64:0] end65(logic [63:0] b, logic [63:0] l);
		return {1'b0, b} + {1'b0, l};
	endfunction

	function automatic bit gap_fit(logic [64:0] gb, logic [63:0] ge, logic [5:0] a,
			logic [63:0] l, output logic [63:0] pos);
		logic [63:0] m;
		logic [64:0] s, e;
		pos = '0;
		if (gb[64]) return 0;
		m = (64'd1 << a) - 64'd1;
		s = {1'b0, gb[63:0]} + {1'b0, m};
		if (s[64]) return 0;
		pos = s[63:0] & ~m;
		if (!(pos < ge)) return 0;
		e = {1'b0, pos} + {1'b0, l};
		return e <= {1'b0, ge};
	endfunction

	task automatic place_entry(int p, logic [63:0] b, logic [63:0] l, logic [7:0] t);
		for (int i = tbl_count; i > p; i--) begin
			tbl_base[i] = tbl_base[i-1];
			tbl_len[i] = tbl_len[i-1];
			tbl_tag[i] = tbl_tag[i-1];
		end
		tbl_base[p] = b;
		tbl_len[p] = l;
		tbl_tag[p] = t;
		tbl_count++;
	endtask

	task automatic predict_alloc(req_t r);
		resp_t o;
		logic [64:0] fe, ee, gb;
		logic [63:0] ge, pos;
		int i;
		bit ok;
		o = '{ST_NOTFOUND, '0, '0, '0};
		case (r.act)
			ACT_INSERT: begin
				if (tbl_count >= MAX_RANGES) o.st = ST_FULL;
				else begin
					fe = end65(r.base, r.len);
					o.st = ST_OK;
					for (i = 0; i < tbl_count; i++) begin
						ee = end65(tbl_base[i], tbl_len[i]);
						if ({1'b0, r.base} < ee && {1'b0, tbl_base[i]} < fe) begin
							o.st = ST_OVERLAP;
							break;
						end
					end
					if (o.st == ST_OK) begin
						i = 0;
						while (i < tbl_count && tbl_base[i] <= r.base) i++;
						place_entry(i, r.base, r.len, r.tag);
						o = '{ST_OK, r.base, r.len, r.tag};
					end
				end
			end
			ACT_ALLOC: begin
				if (tbl_count >= MAX_RANGES) o.st = ST_FULL;
				else begin
					ok = 0;
					gb = {1'b0, win_lo};
					for (i = 0; i < tbl_count; i++) begin
						ge = tbl_base[i] < win_hi ? tbl_base[i] : win_hi;
						if (gap_fit(gb, ge, r.aln, r.len, pos)) begin
							ok = 1;
							break;
						end
						ee = end65(tbl_base[i], tbl_len[i]);
						gb = ee > {1'b0, win_lo} ? ee : {1'b0, win_lo};
					end
					if (!ok && gap_fit(gb, win_hi, r.aln, r.len, pos)) begin
						ok = 1;
						i = tbl_count;
					end
					if (ok) begin
						place_entry(i, pos, r.len, r.tag);
						o = '{ST_OK, pos, r.len, r.tag};
					end else o.st = ST_NOFIT;
				end
			end
			ACT_LOOKUP: begin
				for (i = 0; i < tbl_count; i++) begin
					ee = end65(tbl_base[i], tbl_len[i]);
					if (r.addr >= tbl_base[i] && {1'b0, r.addr} < ee) begin
						o = '{ST_OK, tbl_base[i], tbl_len[i], tbl_tag[i]};
						break;
					end
				end
			end
			default: ;
		endcase
		expected_resp.push_back(o);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// biased towards small sizes and low alignments so the table fills
	function automatic req_t rand_req();
		req_t r;
		int k;
		r.base = rnd64();
		r.len = rnd64();
		r.aln = 6'($urandom_range(0, 63));
		r.tag = 8'($urandom);
		r.addr = rnd64();
		k = $urandom_range(0, 99);
		r.act = k < 30 ? ACT_INSERT : k < 65 ? ACT_ALLOC : k < 97 ? ACT_LOOKUP : ACT_NONE;
		if ($urandom_range(0, 9) < 8) begin
			r.base = win_lo + $urandom_range(0, 4095);
			r.len = $urandom_range(0, 9) == 0 ? 64'd0 : $urandom_range(1, 256);
			r.aln = $urandom_range(0, 9) == 0 ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 6));
			if (tbl_count > 0 && $urandom_range(0, 1)) begin
				k = $urandom_range(0, tbl_count - 1);
				r.addr = tbl_base[k] + $urandom_range(0, 3) - 1;
			end else r.addr = win_lo + $urandom_range(0, 8191);
		end
		return r;
	endfunction

	task automatic push_req(logic [1:0] a, logic [63:0] b, logic [63:0] l, logic [5:0] al,
			logic [7:0] t, logic [63:0] ad);
		req_t r;
		r = '{a, b, l, al, t, ad};
		pending.push_back(r);
	endtask

	task automatic drain();
		while (pending.size() > 0 || n_sent != n_done || expected_resp.size() > 0)
			@(posedge clk);
		repeat (2 * MAX_RANGES + 10) @(posedge clk);
	endtask

	task automatic write_window(logic [63:0] lo, logic [63:0] hi);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= REG_WINDOW_START;
		cfg_data <= lo;
		@(negedge clk);
		cfg_idx <= REG_WINDOW_END;
		cfg_data <= hi;
		@(negedge clk);
		cfg_wen <= 1'b0;
		win_lo = lo;
		win_hi = hi;
	endtask

	// driver: one transfer at a time, prediction made when start is raised
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && took) begin
				start <= 1'b0;
			end
			if (n_sent == n_done && pending.size() > 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				req_t r;
				r = pending.pop_front();
				action <= r.act;
				fixed_base <= r.base;
				length <= r.len;
				align_log2 <= r.aln;
				range_id <= r.tag;
				lookup_addr <= r.addr;
				start <= 1'b1;
				n_sent++;
				predict_alloc(r);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			took = start && !busy;
			stall_cycles <= (done || (start && !busy)) ? 0 : stall_cycles + 1;
			if (done) begin
				n_done++;
				if (expected_resp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transfer st=%0d", status);
				end else begin
					resp_t e;
					e = expected_resp.pop_front();
					if (status !== e.st || result_base !== e.rb || result_length !== e.rl
							|| result_id !== e.rt) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp st=%0d b=%h l=%h id=%h got st=%0d b=%h l=%h id=%h",
								e.st, e.rb, e.rl, e.rt, status, result_base, result_length, result_id);
					end
				end
			end
			if (stall_cycles > 20000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		tbl_count = 0;
		win_lo = '0;
		win_hi = '1;
		send_idle_pct = 13;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		push_req(ACT_LOOKUP, 0, 0, 0, 0, 0);
		push_req(ACT_INSERT, 64'h100, 64'h0, 0, 8'h01, 0);
		push_req(ACT_INSERT, 64'h100, 64'h10, 0, 8'hff, 0);
		push_req(ACT_INSERT, 64'h108, 64'h4, 0, 8'h02, 0);
		push_req(ACT_INSERT, '1, 64'h1, 0, 8'h03, 0);
		push_req(ACT_INSERT, 64'h8000_0000_0000_0000, '1, 0, 8'h04, 0);
		push_req(ACT_LOOKUP, 0, 0, 0, 0, 64'h100);
		push_req(ACT_LOOKUP, 0, 0, 0, 0, 64'h110);
		push_req(ACT_LOOKUP, 0, 0, 0, 0, '1);
		push_req(ACT_ALLOC, 0, 64'h20, 6'd0, 8'h05, 0);
		push_req(ACT_ALLOC, 0, 64'h0, 6'd4, 8'h06, 0);
		push_req(ACT_ALLOC, 0, 64'h40, 6'd63, 8'h07, 0);
		push_req(ACT_ALLOC, 0, '1, 6'd0, 8'h08, 0);
		push_req(ACT_NONE, '1, '1, '1, '1, '1);
		drain();
		write_window(64'h1000, 64'h2000);
		push_req(ACT_ALLOC, 0, 64'h800, 6'd12, 8'h09, 0);
		push_req(ACT_ALLOC, 0, 64'h1000, 6'd0, 8'h0a, 0);
		push_req(ACT_ALLOC, 0, 64'h10, 6'd3, 8'h0b, 0);
		drain();
		write_window(64'h3000, 64'h2000);
		push_req(ACT_ALLOC, 0, 64'h0, 6'd0, 8'h0c, 0);
		drain();
		write_window(64'h0, '1);
		for (int i = 0; i < 70; i++) push_req(ACT_ALLOC, 0, 64'h1, 6'd0, 8'(i), 0);
		push_req(ACT_INSERT, 64'h9000, 64'h1, 0, 8'h0d, 0);
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 13 : ph == 1 ? 83 : 0;
			for (int s = 0; s < 5; s++) begin
				// move the window: reset happens only once, so the table is not cleared
				write_window(rnd64() & 64'hffff_ffff_ffff_0000 | ($urandom_range(0, 1) ? 0 : '1),
					'1);
				if ($urandom_range(0, 3) == 0) write_window(0, '1);
				else if ($urandom_range(0, 3) == 0) write_window(win_lo, win_lo + 64'h3000);
				for (int n = 0; n < 127; n++) pending.push_back(rand_req());
				drain();
			end
		end
		if (mismatches == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/affra_pkg.sv
hw/rtl/affra_ram.sv
hw/rtl/affra_eval.sv
hw/rtl/aligned_first_fit_range_allocator_top.sv
verif/tb.sv
